@@ rtl/mtep_pkg.sv @@
// Shared types and constants for the MIDI track event parser.
package mtep_pkg;

    // Parser phases
    localparam logic [3:0] PH_DELTA     = 4'd0;
    localparam logic [3:0] PH_STATUS    = 4'd1;
    localparam logic [3:0] PH_NOTE_KEY  = 4'd2;
    localparam logic [3:0] PH_NOTE_VEL  = 4'd3;
    localparam logic [3:0] PH_SKIP      = 4'd4;
    localparam logic [3:0] PH_META_ID   = 4'd5;
    localparam logic [3:0] PH_META_LEN  = 4'd6;
    localparam logic [3:0] PH_TEMPO     = 4'd7;
    localparam logic [3:0] PH_SYSEX_LEN = 4'd8;

    // Result kinds
    localparam logic [2:0] K_NOTE_OFF   = 3'd0;
    localparam logic [2:0] K_NOTE_ON    = 3'd1;
    localparam logic [2:0] K_TEMPO      = 3'd2;
    localparam logic [2:0] K_END_TRACK  = 3'd3;
    localparam logic [2:0] K_BAD_STATUS = 3'd4;
    localparam logic [2:0] K_NO_RUNNING = 3'd5;

    // Status and meta codes
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_CH_PRESS = 4'hD;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;

    localparam int DELTA_W = 28;
    localparam int TEMPO_W = 24;

    typedef struct packed {
        logic [3:0]         phase;
        logic [DELTA_W-1:0] vlq_acc;
        logic [DELTA_W-1:0] held_delta;
        logic [7:0]         running_status;
        logic               is_note_on;
        logic [7:0]         first_data;
        logic [7:0]         meta_kind;
        logic [DELTA_W-1:0] skip_left;
        logic [TEMPO_W-1:0] tempo_acc;
        logic [1:0]         tempo_cnt;
        logic               halted;
    } t_state;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo_usec;
        logic [7:0]         note_velocity;
        logic [7:0]         note_number;
        logic [DELTA_W-1:0] delta_ticks;
        logic [2:0]         result_kind;
    } t_result;

endpackage

@@ rtl/mtep_step.sv @@
// Next-state and result logic for one track byte.
module mtep_step import mtep_pkg::*; #(
    parameter int MAX_VLQ_BYTES = 4,
    parameter int CW = 2
) (
    input  t_state          i_st,
    input  logic [CW-1:0]   i_vlq_cnt,
    input  logic [7:0]      i_byte,
    input  logic            i_track_start,
    output t_state          o_st,
    output logic [CW-1:0]   o_vlq_cnt,
    output logic            o_emit,
    output t_result         o_res
);

    localparam logic [CW:0] VLQ_LAST = (CW+1)'(MAX_VLQ_BYTES);

    t_state             st;
    t_state             nx;
    logic [CW-1:0]      cnt;
    logic [CW-1:0]      n_cnt;
    logic [CW:0]        cnt_inc;
    logic [DELTA_W-1:0] acc_take;
    logic               vlq_last;
    logic [DELTA_W-1:0] skip_dec;
    logic [TEMPO_W-1:0] tempo_take;
    logic [3:0]         nib;
    logic               have_data;
    logic               emit;
    t_result            res;

    always_comb begin
        st  = i_st;
        cnt = i_vlq_cnt;
        if (i_track_start) begin
            st  = '0;
            cnt = '0;
        end

        cnt_inc    = {1'b0, cnt} + 1'b1;
        acc_take   = {st.vlq_acc[DELTA_W-8:0], i_byte[6:0]};
        vlq_last   = !i_byte[7] || (cnt_inc >= VLQ_LAST);
        skip_dec   = st.skip_left - 1'b1;
        tempo_take = {st.tempo_acc[TEMPO_W-9:0], i_byte};
        nib        = (i_byte[7]) ? i_byte[7:4] : st.running_status[7:4];
        have_data  = !i_byte[7];

        nx    = st;
        n_cnt = cnt;
        emit  = 1'b0;
        res   = '0;
        res.delta_ticks = st.held_delta;

        if (!st.halted) begin
            case (st.phase)
                PH_DELTA: begin
                    if (vlq_last) begin
                        nx.held_delta = acc_take;
                        nx.vlq_acc    = '0;
                        n_cnt         = '0;
                        nx.phase      = PH_STATUS;
                    end else begin
                        nx.vlq_acc = acc_take;
                        n_cnt      = cnt_inc[CW-1:0];
                    end
                end
                PH_STATUS: begin
                    if (i_byte == ST_META) begin
                        nx.running_status = '0;
                        nx.phase          = PH_META_ID;
                    end else if (i_byte == ST_SYSEX || i_byte == ST_SYSEX_ESC) begin
                        nx.running_status = '0;
                        nx.phase          = PH_SYSEX_LEN;
                    end else if (i_byte[7:4] == ST_SYSEX[7:4]) begin
                        nx.halted       = 1'b1;
                        emit            = 1'b1;
                        res.result_kind = K_BAD_STATUS;
                    end else if (have_data && st.running_status == 8'd0) begin
                        nx.halted       = 1'b1;
                        emit            = 1'b1;
                        res.result_kind = K_NO_RUNNING;
                    end else begin
                        // channel event, possibly under running status
                        if (i_byte[7]) begin
                            nx.running_status = i_byte;
                        end
                        nx.is_note_on = (nib == NIB_NOTE_ON);
                        if (nib == NIB_NOTE_OFF || nib == NIB_NOTE_ON) begin
                            if (have_data) begin
                                nx.first_data = i_byte;
                                nx.phase      = PH_NOTE_VEL;
                            end else begin
                                nx.phase = PH_NOTE_KEY;
                            end
                        end else if (nib == NIB_PROGRAM || nib == NIB_CH_PRESS) begin
                            nx.skip_left = have_data ? DELTA_W'(0) : DELTA_W'(1);
                            nx.phase     = have_data ? PH_DELTA : PH_SKIP;
                        end else begin
                            nx.skip_left = have_data ? DELTA_W'(1) : DELTA_W'(2);
                            nx.phase     = PH_SKIP;
                        end
                    end
                end
                PH_NOTE_KEY: begin
                    nx.first_data = i_byte;
                    nx.phase      = PH_NOTE_VEL;
                end
                PH_NOTE_VEL: begin
                    nx.phase          = PH_DELTA;
                    emit              = 1'b1;
                    res.result_kind   = (st.is_note_on && i_byte != 8'd0) ?
                                        K_NOTE_ON : K_NOTE_OFF;
                    res.note_number   = st.first_data;
                    res.note_velocity = i_byte;
                end
                PH_SKIP: begin
                    nx.skip_left = skip_dec;
                    if (skip_dec == '0) begin
                        nx.phase = PH_DELTA;
                    end
                end
                PH_META_ID: begin
                    nx.meta_kind = i_byte;
                    nx.phase     = PH_META_LEN;
                end
                PH_META_LEN: begin
                    if (vlq_last) begin
                        nx.vlq_acc   = '0;
                        n_cnt        = '0;
                        nx.skip_left = acc_take;
                        if (st.meta_kind == META_EOT) begin
                            nx.halted       = 1'b1;
                            nx.phase        = PH_DELTA;
                            emit            = 1'b1;
                            res.result_kind = K_END_TRACK;
                        end else if (st.meta_kind == META_TEMPO) begin
                            nx.tempo_acc = '0;
                            nx.tempo_cnt = '0;
                            nx.phase     = PH_TEMPO;
                        end else begin
                            nx.phase = (acc_take == '0) ? PH_DELTA : PH_SKIP;
                        end
                    end else begin
                        nx.vlq_acc = acc_take;
                        n_cnt      = cnt_inc[CW-1:0];
                    end
                end
                PH_TEMPO: begin
                    nx.tempo_acc = tempo_take;
                    if (st.tempo_cnt < 2'd2) begin
                        nx.tempo_cnt = st.tempo_cnt + 2'd1;
                    end else begin
                        // excess meta length past the three tempo bytes is skipped
                        nx.tempo_cnt = '0;
                        nx.skip_left = (st.skip_left > DELTA_W'(3)) ?
                                       st.skip_left - DELTA_W'(3) : '0;
                        nx.phase     = (st.skip_left > DELTA_W'(3)) ? PH_SKIP : PH_DELTA;
                        emit           = 1'b1;
                        res.result_kind = K_TEMPO;
                        res.tempo_usec  = tempo_take;
                    end
                end
                PH_SYSEX_LEN: begin
                    if (vlq_last) begin
                        nx.vlq_acc   = '0;
                        n_cnt        = '0;
                        nx.skip_left = acc_take;
                        nx.phase     = (acc_take == '0) ? PH_DELTA : PH_SKIP;
                    end else begin
                        nx.vlq_acc = acc_take;
                        n_cnt      = cnt_inc[CW-1:0];
                    end
                end
                default: begin
                    nx.phase = PH_DELTA;
                end
            endcase
        end
    end

    assign o_st      = nx;
    assign o_vlq_cnt = n_cnt;
    assign o_emit    = emit;
    assign o_res     = res;

endmodule

@@ rtl/midi_track_event_parser_core.sv @@
// Top level of the MIDI track event parser: byte stream in, note/tempo/end events out.
// A result is registered and appears on the master side in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the output register is empty or being drained; the parser
// state update and result selection sit between the state registers and a single output register.
// The slave side stays ready while the output register is empty or being drained.
// Reset (i_rst_n low, synchronous) clears the parser state and drops any pending result.
module midi_track_event_parser_core import mtep_pkg::*; #(
    parameter int MAX_VLQ_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tuser,   // [0] track_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [27:0] delta_ticks, [35:28] note_number, [43:36] note_velocity,
    // [67:44] tempo_usec, [71:68] zero
    output logic [71:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // [2:0] result_kind
);

    // VLQ byte counter only needs to reach MAX_VLQ_BYTES-1
    localparam int CW = (MAX_VLQ_BYTES > 1) ? $clog2(MAX_VLQ_BYTES) : 1;

    t_state          r_st;
    t_state          n_st;
    logic [CW-1:0]   r_vlq_cnt;
    logic [CW-1:0]   n_vlq_cnt;
    logic            step_emit;
    t_result         step_res;
    logic            r_out_valid;
    t_result         r_out;
    logic            s_acc;

    // A request is taken whenever the result register can accept a new result
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    mtep_step #(
        .MAX_VLQ_BYTES (MAX_VLQ_BYTES),
        .CW            (CW)
    ) u_step (
        .i_st          (r_st),
        .i_vlq_cnt     (r_vlq_cnt),
        .i_byte        (s_axis_tdata),
        .i_track_start (s_axis_tuser),
        .o_st          (n_st),
        .o_vlq_cnt     (n_vlq_cnt),
        .o_emit        (step_emit),
        .o_res         (step_res)
    );

    // Parser state advances only on an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= '0;
            r_vlq_cnt <= '0;
        end else if (s_acc) begin
            r_st      <= n_st;
            r_vlq_cnt <= n_vlq_cnt;
        end
    end

    // Output register: loaded by a result, emptied when the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && step_emit) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.result_kind;
    assign m_axis_tdata  = {4'd0, r_out.tempo_usec, r_out.note_velocity,
                            r_out.note_number, r_out.delta_ticks};

`ifndef SYNTHESIS
    // Halted parser must not produce a new result for a byte without track start
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_st.halted && !s_axis_tuser) |=>
        (m_axis_tvalid == $past(m_axis_tvalid && !m_axis_tready)))
        else $error("result produced while halted");

    // VLQ counter never reaches the byte limit
    a_vlq_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_vlq_cnt} < (CW+1)'(MAX_VLQ_BYTES)))
        else $error("VLQ byte counter out of range");

    // Only note results carry note fields, only tempo results carry a tempo
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        ((m_axis_tuser == K_NOTE_OFF || m_axis_tuser == K_NOTE_ON ||
          m_axis_tdata[43:28] == 16'd0) &&
         (m_axis_tuser == K_TEMPO || m_axis_tdata[67:44] == 24'd0)))
        else $error("result fields inconsistent with kind");

    // Terminal results always leave the parser halted
    a_halt_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && step_emit && (step_res.result_kind == K_END_TRACK ||
         step_res.result_kind == K_BAD_STATUS || step_res.result_kind == K_NO_RUNNING))
        |=> r_st.halted)
        else $error("parser not halted after terminal result");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the MIDI track event parser core, with its own event predictor.
module testbench;
    import mtep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VLQ_MAX      = 4;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
    localparam int PHASE_BYTES  = 120;
    localparam int PHASE_COUNT  = 8;

    typedef struct {
        logic [7:0] value;
        logic       start;
    } t_midi_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] byte_value
    logic        s_axis_tuser = 1'b0;  // [0] track_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [27:0] delta_ticks, [35:28] note_number, [43:36] note_velocity,
    // [67:44] tempo_usec, [71:68] zero
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;         // [2:0] result_kind

    midi_track_event_parser_core #(.MAX_VLQ_BYTES(VLQ_MAX)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_midi_byte  track_bytes [$];   // bytes waiting to be sent
    t_result     due_events [$];    // predicted events not yet seen
    t_midi_byte  next_byte;
    bit          byte_taken;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned idle_plan [4] = '{0, 57, 0, 11};
    int unsigned stall_plan [4] = '{0, 0, 57, 11};
    int          err_count = 0;
    int          quiet_cycles = 0;
    t_result     want;
    t_result     predicted;

    // Stimulus generator state
    bit          gen_start;
    logic [7:0]  gen_status;  // last channel status, for running status

    // ---------------------------------------------------------------
    // Event predictor
    // ---------------------------------------------------------------
    logic [3:0]  ph;
    logic [27:0] vlq_acc;
    int          vlq_cnt;
    logic [27:0] held_delta;
    logic [7:0]  run_status;
    logic [3:0]  ev_nib;
    logic [7:0]  first_byte;
    logic [7:0]  meta_code;
    logic [27:0] skip_left;
    logic [23:0] tempo_acc;
    int          tempo_cnt;
    bit          halted;

    function automatic void clear_parser();
        ph         = PH_DELTA;
        vlq_acc    = '0;
        vlq_cnt    = 0;
        held_delta = '0;
        run_status = '0;
        ev_nib     = '0;
        first_byte = '0;
        meta_code  = '0;
        skip_left  = '0;
        tempo_acc  = '0;
        tempo_cnt  = 0;
        halted     = 1'b0;
    endfunction

    // Shifts one byte into the quantity; true when it is complete.
    function automatic bit vlq_feed(input logic [7:0] b);
        bit done;
        vlq_acc = {vlq_acc[20:0], b[6:0]};
        done = !b[7] || (vlq_cnt + 1 >= VLQ_MAX);
        vlq_cnt = done ? 0 : vlq_cnt + 1;
        return done;
    endfunction

    function automatic logic [27:0] vlq_take();
        logic [27:0] v;
        v = vlq_acc;
        vlq_acc = '0;
        vlq_cnt = 0;
        return v;
    endfunction

    function automatic void begin_skip(input logic [27:0] n);
        skip_left = n;
        ph = (n == 0) ? PH_DELTA : PH_SKIP;
    endfunction

    function automatic void begin_channel(input logic [3:0] nib, input bit have_data,
                                          input logic [7:0] b);
        ev_nib = nib;
        if (nib == NIB_NOTE_OFF || nib == NIB_NOTE_ON) begin
            if (have_data) begin
                first_byte = b;
                ph = PH_NOTE_VEL;
            end else begin
                ph = PH_NOTE_KEY;
            end
        end else if (nib == NIB_PROGRAM || nib == NIB_CH_PRESS) begin
            begin_skip(have_data ? 28'd0 : 28'd1);
        end else begin
            begin_skip(have_data ? 28'd1 : 28'd2);
        end
    endfunction

    function automatic bit parse_track_byte(input logic [7:0] b, input logic start,
                                            output t_result ev);
        bit hit;
        hit = 1'b0;
        ev = '0;
        if (start)
            clear_parser();
        if (halted)
            return 1'b0;
        case (ph)
            PH_DELTA: begin
                if (vlq_feed(b)) begin
                    held_delta = vlq_take();
                    ph = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (b == ST_META) begin
                    run_status = '0;
                    ph = PH_META_ID;
                end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                    run_status = '0;
                    ph = PH_SYSEX_LEN;
                end else if (b[7:4] == ST_SYSEX[7:4]) begin
                    halted = 1'b1;
                    hit = 1'b1;
                    ev.result_kind = K_BAD_STATUS;
                end else if (b[7]) begin
                    run_status = b;
                    begin_channel(b[7:4], 1'b0, b);
                end else if (run_status == 0) begin
                    halted = 1'b1;
                    hit = 1'b1;
                    ev.result_kind = K_NO_RUNNING;
                end else begin
                    begin_channel(run_status[7:4], 1'b1, b);
                end
            end
            PH_NOTE_KEY: begin
                first_byte = b;
                ph = PH_NOTE_VEL;
            end
            PH_NOTE_VEL: begin
                ph = PH_DELTA;
                hit = 1'b1;
                ev.result_kind = (ev_nib == NIB_NOTE_ON && b != 0) ? K_NOTE_ON : K_NOTE_OFF;
                ev.note_number = first_byte;
                ev.note_velocity = b;
            end
            PH_SKIP: begin
                skip_left = skip_left - 28'd1;
                if (skip_left == 0)
                    ph = PH_DELTA;
            end
            PH_META_ID: begin
                meta_code = b;
                ph = PH_META_LEN;
            end
            PH_META_LEN: begin
                if (vlq_feed(b)) begin
                    skip_left = vlq_take();
                    if (meta_code == META_EOT) begin
                        halted = 1'b1;
                        ph = PH_DELTA;
                        hit = 1'b1;
                        ev.result_kind = K_END_TRACK;
                    end else if (meta_code == META_TEMPO) begin
                        tempo_acc = '0;
                        tempo_cnt = 0;
                        ph = PH_TEMPO;
                    end else begin
                        begin_skip(skip_left);
                    end
                end
            end
            PH_TEMPO: begin
                tempo_acc = {tempo_acc[15:0], b};
                if (tempo_cnt < 2) begin
                    tempo_cnt++;
                end else begin
                    // Three tempo bytes read whatever the length; excess is skipped
                    tempo_cnt = 0;
                    begin_skip(skip_left > 3 ? skip_left - 28'd3 : 28'd0);
                    hit = 1'b1;
                    ev.result_kind = K_TEMPO;
                    ev.tempo_usec = tempo_acc;
                end
            end
            PH_SYSEX_LEN: begin
                if (vlq_feed(b))
                    begin_skip(vlq_take());
            end
            default: ph = PH_DELTA;
        endcase
        if (hit)
            ev.delta_ticks = held_delta;
        return hit;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] b);
        t_midi_byte item;
        item.value = b;
        item.start = gen_start;
        gen_start = 1'b0;
        track_bytes.insert(track_bytes.size(), item);
    endfunction

    // Big-endian 7-bit groups; pad adds leading empty groups up to the limit.
    function automatic void queue_vlq(input logic [27:0] v, input bit pad);
        int n;
        n = 1;
        while (n < VLQ_MAX && (v >> (7 * n)) != 0)
            n++;
        if (pad && n < VLQ_MAX)
            n = $urandom_range(VLQ_MAX, n);
        for (int i = n - 1; i >= 0; i--)
            queue_byte({(i != 0), 7'(v >> (7 * i))});
    endfunction

    function automatic logic [27:0] random_delta();
        int w;
        w = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 28);
        return 28'($urandom & ((32'd1 << w) - 32'd1));
    endfunction

    function automatic logic [7:0] random_bad_status();
        logic [7:0] b;
        do
            b = 8'($urandom_range(8'hFE, 8'hF1));
        while (b == ST_SYSEX_ESC);
        return b;
    endfunction

    function automatic void queue_event();
        int         pick;
        int         len;
        logic [3:0] nib;
        logic [7:0] mtype;
        pick = $urandom_range(0, 99);
        queue_vlq(random_delta(), $urandom_range(0, 3) == 0);
        if (pick < 55) begin
            if (gen_status != 0 && $urandom_range(0, 2) == 0) begin
                nib = gen_status[7:4];  // running status: no status byte
            end else begin
                if ($urandom_range(0, 9) < 6)
                    nib = $urandom_range(0, 1) ? NIB_NOTE_ON : NIB_NOTE_OFF;
                else
                    nib = 4'($urandom_range(4'hE, 4'hA));
                gen_status = {nib, 4'($urandom_range(0, 15))};
                queue_byte(gen_status);
            end
            if (nib == NIB_NOTE_ON || nib == NIB_NOTE_OFF) begin
                queue_byte(8'($urandom_range(0, 127)));
                queue_byte(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 127)));
            end else begin
                len = (nib == NIB_PROGRAM || nib == NIB_CH_PRESS) ? 1 : 2;
                repeat (len) queue_byte(8'($urandom_range(0, 127)));
            end
        end else if (pick < 70) begin
            queue_byte(ST_META);
            queue_byte(META_TEMPO);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 3;
            queue_vlq(28'(len), 1'b0);
            repeat (3) queue_byte(8'($urandom_range(0, 255)));
            if (len > 3)
                repeat (len - 3) queue_byte(8'($urandom_range(0, 255)));
            gen_status = '0;
        end else if (pick < 85) begin
            mtype = 8'($urandom_range(0, 255));
            if (mtype == META_EOT || mtype == META_TEMPO)
                mtype[7] = 1'b1;
            queue_byte(ST_META);
            queue_byte(mtype);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 160) : $urandom_range(0, 6);
            queue_vlq(28'(len), $urandom_range(0, 3) == 0);
            repeat (len) queue_byte(8'($urandom_range(0, 255)));
            gen_status = '0;
        end else begin
            queue_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
            len = $urandom_range(0, 8);
            queue_vlq(28'(len), 1'b0);
            repeat (len) queue_byte(8'($urandom_range(0, 255)));
            gen_status = '0;
        end
    endfunction

    function automatic void queue_track();
        int ending;
        ending = $urandom_range(0, 99);
        gen_start = 1'b1;
        gen_status = '0;
        repeat ($urandom_range(1, 10)) queue_event();
        if (ending < 70) begin
            queue_vlq(random_delta(), 1'b0);
            queue_byte(ST_META);
            queue_byte(META_EOT);
            queue_vlq(28'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : 0), 1'b0);
            // parser is halted now; these go nowhere
            repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)));
        end else if (ending < 80) begin
            queue_vlq(random_delta(), 1'b0);
            queue_byte(random_bad_status());
        end else if (ending < 88) begin
            // sysex cancels running status, so the next data byte is an error
            queue_vlq(random_delta(), 1'b0);
            queue_byte(ST_SYSEX);
            queue_byte(8'd0);
            queue_vlq(random_delta(), 1'b0);
            queue_byte(8'($urandom_range(0, 127)));
        end else begin
            repeat ($urandom_range(5, 20)) begin
                gen_start = ($urandom_range(0, 15) == 0);
                queue_byte(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    function automatic void queue_directed();
        gen_start = 1'b1;
        // note on, key and velocity at their extremes
        queue_byte(8'd0);
        queue_byte({NIB_NOTE_ON, 4'h0});
        queue_byte(8'd0);
        queue_byte(8'hFF);
        // delta cut off at its fourth byte (max value), then running status
        // with velocity zero, reported as note off
        repeat (4) queue_byte(8'hFF);
        queue_byte(8'h7F);
        queue_byte(8'd0);
        // tempo with length 4: max tempo, one byte of excess skipped
        queue_byte(8'd0);
        queue_byte(ST_META);
        queue_byte(META_TEMPO);
        queue_byte(8'd4);
        repeat (3) queue_byte(8'hFF);
        queue_byte(8'd0);
        // sysex, then a data byte with running status cancelled
        queue_byte(8'd0);
        queue_byte(ST_SYSEX);
        queue_byte(8'd1);
        queue_byte(8'h5A);
        queue_byte(8'd0);
        queue_byte(8'h20);
        queue_byte({NIB_NOTE_ON, 4'hF});  // ignored while halted
        // new track: bad status
        gen_start = 1'b1;
        queue_byte(8'd0);
        queue_byte(random_bad_status());
        // new track: end of track
        gen_start = 1'b1;
        queue_byte(8'd0);
        queue_byte(ST_META);
        queue_byte(META_EOT);
        queue_byte(8'd0);
    endfunction

    // ---------------------------------------------------------------
    // Driver: accepted requests feed the predictor, next byte at falling edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        byte_taken = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            byte_taken = 1'b1;
            if (parse_track_byte(s_axis_tdata, s_axis_tuser, predicted))
                due_events.insert(due_events.size(), predicted);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || byte_taken)) begin
            if (track_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_byte = track_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_byte.value;
                s_axis_tuser  <= next_byte.start;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------
    // Monitor
    // ---------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name,
                     exp_val, got_val);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_events.size() == 0) begin
                $display("%0t: unexpected event: expected none, actual kind %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                err_count++;
            end else begin
                want = due_events.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(m_axis_tuser));
                check_field("delta_ticks", 32'(want.delta_ticks), 32'(m_axis_tdata[27:0]));
                check_field("note_number", 32'(want.note_number), 32'(m_axis_tdata[35:28]));
                check_field("note_velocity", 32'(want.note_velocity),
                            32'(m_axis_tdata[43:36]));
                check_field("tempo_usec", 32'(want.tempo_usec), 32'(m_axis_tdata[67:44]));
                check_field("tdata pad", 32'd0, 32'(m_axis_tdata[71:68]));
            end
        end
    end

    // Watchdog: ends the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, then phases of idle/stall mix, each drained fully
    // ---------------------------------------------------------------
    initial begin
        clear_parser();
        gen_start = 1'b0;
        gen_status = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            send_idle_pct = idle_plan[p % 4];
            stall_pct = stall_plan[p % 4];
            if (p == 0)
                queue_directed();
            while (track_bytes.size() < PHASE_BYTES)
                queue_track();
            // sender holds off until every predicted event has come back
            while (track_bytes.size() != 0 || s_axis_tvalid || due_events.size() != 0)
                @(posedge i_clk);
            repeat (4) @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
